/* src/sfcp_pkg.sv */
package sfcp_pkg;

  localparam int FrameLen = 24;
  localparam int PosW = 5;
  localparam int QuoW = 27;
  localparam int RecipShift = 37;

  localparam logic [7:0] SyncByte = 8'h5a;
  localparam logic [7:0] KindByte = 8'h15;

  // ceil(2^37 / 100), exact quotient for every 32-bit dividend
  localparam logic [31:0] Recip100 = 32'h51eb_851f;

  typedef logic [7:0] byte_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [QuoW-1:0] quo_t;

  localparam pos_t LastPos = pos_t'(FrameLen - 1);

endpackage

/* src/sfcp_if.sv */
interface sfcp_in_if import sfcp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcp_out_if ();
  logic               valid;
  logic               ready;
  logic signed [26:0] light_level;
  logic               light_ok;
  logic signed [10:0] temperature;
  logic signed [26:0] air_pressure;
  logic signed [10:0] humidity;
  logic signed [16:0] altitude;
  logic               env_ok;

  modport source (
    output valid, output light_level, output light_ok, output temperature,
    output air_pressure, output humidity, output altitude, output env_ok,
    input ready
  );
  modport sink (
    input valid, input light_level, input light_ok, input temperature,
    input air_pressure, input humidity, input altitude, input env_ok,
    output ready
  );
endinterface

/* src/sfcp_cell.sv */
module sfcp_cell import sfcp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  byte_t d,
  output byte_t q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

/* src/sfcp_div100.sv */
module sfcp_div100 import sfcp_pkg::*; (
  input  logic        clk,
  input  logic [31:0] x,
  output quo_t        q
);

  logic [63:0] prod;

  always_ff @(posedge clk) begin
    prod <= 64'(x) * 64'(Recip100);
  end

  assign q = prod[RecipShift +: QuoW];

endmodule

/* src/sensor_frame_checksum_parser_core.sv */
// Throughput: one byte per cycle; the last byte of a frame waits only while the
// previous frame is still being divided or is waiting for the output to take it.
// Once the last byte of a frame is accepted, four passes through one shared 32x32
// reciprocal multiplier form the quotients before the result is registered.
// Reset: synchronous, clears the byte count and output valid, sets held values to -1.
module sensor_frame_checksum_parser_core import sfcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sfcp_in_if.sink    rx,
  sfcp_out_if.source res
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t             state;
  logic [2:0]         step;
  pos_t               pos;
  byte_t              sum_a;
  byte_t              sum_b;
  logic               light_flag;
  byte_t              cell_q [FrameLen];
  logic [31:0]        op [4];
  quo_t               quo [4];
  logic [15:0]        alt_raw;
  logic               light_ok_r;
  logic               env_ok_r;
  logic [31:0]        div_x;
  quo_t               div_q;
  logic               accept;
  logic               complete;
  logic signed [10:0] held_temp;
  logic signed [26:0] held_press;
  logic signed [10:0] held_hum;
  logic signed [16:0] held_alt;
  logic signed [10:0] temp_next;
  logic signed [26:0] press_next;
  logic signed [10:0] hum_next;
  logic signed [16:0] alt_next;

  assign rx.ready = (pos != LastPos) || (state == IDLE);
  assign accept   = rx.valid && rx.ready;
  assign complete = accept && (pos == LastPos);

  for (genvar i = 0; i < FrameLen; i++) begin : g_cell
    byte_t d;
    if (i == 0) begin : g_head
      assign d = rx.rx_byte;
    end else begin : g_body
      assign d = cell_q[i-1];
    end
    sfcp_cell u_cell (.clk(clk), .en(accept), .d(d), .q(cell_q[i]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      priority if ((pos == pos_t'(0) || pos == pos_t'(1)) && rx.rx_byte != SyncByte) begin
        pos <= '0;
      end else if (pos == pos_t'(2) && rx.rx_byte != KindByte) begin
        pos <= '0;
      end else if (pos == LastPos) begin
        pos <= '0;
      end else begin
        pos <= pos + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == pos_t'(0)) begin
        sum_a <= rx.rx_byte;
      end else if (pos <= pos_t'(7)) begin
        sum_a <= sum_a + rx.rx_byte;
      end
      if (pos == pos_t'(8)) begin
        light_flag <= (sum_a == rx.rx_byte);
      end
      if (pos == pos_t'(9)) begin
        sum_b <= rx.rx_byte;
      end else if (pos >= pos_t'(10) && pos <= pos_t'(22)) begin
        sum_b <= sum_b + rx.rx_byte;
      end
    end
    if (complete) begin
      op[0]      <= {cell_q[18], cell_q[17], cell_q[16], cell_q[15]};
      op[1]      <= {16'b0, cell_q[9], cell_q[8]};
      op[2]      <= {cell_q[7], cell_q[6], cell_q[5], cell_q[4]};
      op[3]      <= {16'b0, cell_q[3], cell_q[2]};
      alt_raw    <= {cell_q[1], cell_q[0]};
      light_ok_r <= light_flag;
      env_ok_r   <= (sum_b == rx.rx_byte);
    end
  end

  assign div_x = op[step[1:0]];

  sfcp_div100 u_div (.clk(clk), .x(div_x), .q(div_q));

  assign temp_next  = env_ok_r ? $signed(quo[1][10:0]) : held_temp;
  assign press_next = env_ok_r ? $signed(quo[2]) : held_press;
  assign hum_next   = env_ok_r ? $signed(quo[3][10:0]) : held_hum;
  assign alt_next   = env_ok_r ? $signed({1'b0, alt_raw}) : held_alt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      step       <= '0;
      res.valid  <= 1'b0;
      held_temp  <= '1;
      held_press <= '1;
      held_hum   <= '1;
      held_alt   <= '1;
    end else begin
      if (res.valid && res.ready && state != DONE) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          step <= '0;
          if (complete) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (step != 3'd0) begin
            quo[2'(step - 3'd1)] <= div_q;
          end
          if (step == 3'd4) begin
            state <= DONE;
          end else begin
            step <= step + 3'd1;
          end
        end
        DONE: begin
          if (!res.valid || res.ready) begin
            res.valid        <= 1'b1;
            res.light_level  <= light_ok_r ? $signed(quo[0]) : '1;
            res.light_ok     <= light_ok_r;
            res.temperature  <= temp_next;
            res.air_pressure <= press_next;
            res.humidity     <= hum_next;
            res.altitude     <= alt_next;
            res.env_ok       <= env_ok_r;
            held_temp        <= temp_next;
            held_press       <= press_next;
            held_hum         <= hum_next;
            held_alt         <= alt_next;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* dv/sfcp_frame_checker.sv */
module sfcp_frame_checker import sfcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  sfcp_in_if   rx,
  sfcp_out_if  res,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic signed [26:0] light_level;
    logic               light_ok;
    logic signed [10:0] temperature;
    logic signed [26:0] air_pressure;
    logic signed [10:0] humidity;
    logic signed [16:0] altitude;
    logic               env_ok;
  } reading_t;

  reading_t readings_due[$];

  byte_t              frame_bytes [FrameLen];
  pos_t               byte_pos;
  logic signed [10:0] held_temp;
  logic signed [26:0] held_press;
  logic signed [10:0] held_hum;
  logic signed [16:0] held_alt;

  function automatic void absorb_rx_byte(input byte_t b);
    reading_t    r;
    logic [7:0]  light_sum;
    logic [7:0]  env_sum;
    logic [31:0] quo32;
    logic [15:0] quo16;
    frame_bytes[byte_pos] = b;
    if ((byte_pos <= pos_t'(1) && b != SyncByte) || (byte_pos == pos_t'(2) && b != KindByte)) begin
      byte_pos = '0;
      return;
    end
    if (byte_pos != LastPos) begin
      byte_pos = byte_pos + pos_t'(1);
      return;
    end
    byte_pos = '0;

    light_sum = '0;
    for (int i = 0; i <= 7; i++) light_sum = light_sum + frame_bytes[i];
    env_sum = '0;
    for (int i = 9; i <= 22; i++) env_sum = env_sum + frame_bytes[i];

    r.light_ok = (light_sum == frame_bytes[8]);
    quo32 = {frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7]} / 32'd100;
    r.light_level = r.light_ok ? quo32[26:0] : '1;

    r.env_ok = (env_sum == frame_bytes[23]);
    if (r.env_ok) begin
      quo16 = {frame_bytes[13], frame_bytes[14]} / 16'd100;
      held_temp = quo16[10:0];
      quo32 = {frame_bytes[15], frame_bytes[16], frame_bytes[17], frame_bytes[18]} / 32'd100;
      held_press = quo32[26:0];
      quo16 = {frame_bytes[19], frame_bytes[20]} / 16'd100;
      held_hum = quo16[10:0];
      held_alt = {1'b0, frame_bytes[21], frame_bytes[22]};
    end
    r.temperature  = held_temp;
    r.air_pressure = held_press;
    r.humidity     = held_hum;
    r.altitude     = held_alt;
    readings_due.push_back(r);
  endfunction

  function automatic void compare_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    reading_t r;
    if (rst) begin
      byte_pos   = '0;
      held_temp  = '1;
      held_press = '1;
      held_hum   = '1;
      held_alt   = '1;
      readings_due.delete();
      fail_count = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, got light %0d temp %0d press %0d",
                   $time, res.light_level, res.temperature, res.air_pressure);
          fail_count++;
        end else begin
          r = readings_due.pop_front();
          compare_field("light_level", r.light_level, res.light_level);
          compare_field("light_ok", r.light_ok, res.light_ok);
          compare_field("temperature", r.temperature, res.temperature);
          compare_field("air_pressure", r.air_pressure, res.air_pressure);
          compare_field("humidity", r.humidity, res.humidity);
          compare_field("altitude", r.altitude, res.altitude);
          compare_field("env_ok", r.env_ok, res.env_ok);
        end
      end
      if (rx.valid && rx.ready) absorb_rx_byte(rx.rx_byte);
    end
    pending = readings_due.size();
  end

endmodule

/* dv/tb_sensor_frame_checksum_parser_core.sv */
module tb_sensor_frame_checksum_parser_core;
  import sfcp_pkg::*;

  localparam int ItemTarget  = 1600;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 30;
  localparam int CycleLimit  = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int cycle_count  = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int holds_wanted = 0;
  int holds_done   = 0;
  int fail_count;
  int pending;

  sfcp_in_if  rx ();
  sfcp_out_if res ();

  sensor_frame_checksum_parser_core i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res)
  );

  sfcp_frame_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // call and return at a falling edge
  task automatic send_byte(input byte_t b);
    if (burst_left == 0) begin
      if (holds_done == holds_wanted) begin
        rx.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame(input logic [31:0] lux, input logic [15:0] temp,
                            input logic [31:0] press, input logic [15:0] hum,
                            input logic [15:0] alt, input bit spoil_light, input bit spoil_env);
    byte_t      f [FrameLen];
    logic [7:0] s;
    f[0] = SyncByte;
    f[1] = SyncByte;
    f[2] = KindByte;
    f[3] = 8'($urandom);
    {f[4], f[5], f[6], f[7]} = lux;
    s = '0;
    for (int i = 0; i <= 7; i++) s = s + f[i];
    f[8] = spoil_light ? s + 8'($urandom_range(1, 255)) : s;
    for (int i = 9; i <= 12; i++) f[i] = 8'($urandom);
    {f[13], f[14]} = temp;
    {f[15], f[16], f[17], f[18]} = press;
    {f[19], f[20]} = hum;
    {f[21], f[22]} = alt;
    s = '0;
    for (int i = 9; i <= 22; i++) s = s + f[i];
    f[23] = spoil_env ? s + 8'($urandom_range(1, 255)) : s;
    for (int i = 0; i < FrameLen; i++) send_byte(f[i]);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int stretch;
    int mode;
    res.ready = 1'b0;
    wait (!rst);
    forever begin
      if (holds_done != holds_wanted) begin
        @(negedge clk);
        res.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds_done++;
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(10, 80);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= 1'($urandom_range(0, 1));
          default: res.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // header recovery: bad first sync, bad second sync, bad kind, sync where kind belongs
    send_byte(8'h00);
    send_byte(SyncByte);
    send_byte(8'h00);
    send_byte(SyncByte);
    send_byte(SyncByte);
    send_byte(8'h16);
    send_byte(SyncByte);
    send_byte(SyncByte);
    send_byte(SyncByte);
    send_byte(KindByte);

    send_frame('1, 16'h1234, 32'h0001_0000, 16'h4321, 16'h0101, 1'b0, 1'b1);
    send_frame('0, '0, '0, '0, '0, 1'b0, 1'b0);
    send_frame('1, '1, '1, '1, '1, 1'b0, 1'b0);
    send_frame(32'd99, 16'd99, 32'd100, 16'd100, 16'h8000, 1'b1, 1'b0);
    send_frame($urandom, 16'($urandom), $urandom, 16'($urandom), 16'($urandom), 1'b1, 1'b1);

    while (items_sent < ItemTarget) begin
      if (holds_wanted == 0 && items_sent > 500) holds_wanted = 1;
      if (holds_wanted == 1 && items_sent > 1200) holds_wanted = 2;
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 8)) send_byte($urandom_range(0, 1) ? SyncByte : 8'($urandom));
        1: begin
          send_byte(SyncByte);
          if ($urandom_range(0, 1)) send_byte(SyncByte);
          if ($urandom_range(0, 1)) send_byte($urandom_range(0, 1) ? KindByte : 8'($urandom));
        end
        default: send_frame(pick_word(), 16'(pick_word()), pick_word(), 16'(pick_word()),
                            16'(pick_word()), $urandom_range(0, 4) == 0,
                            $urandom_range(0, 4) == 0);
      endcase
    end
    rx.valid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sensor_frame_checksum_parser_core.f */
src/sfcp_pkg.sv
src/sfcp_if.sv
src/sfcp_cell.sv
src/sfcp_div100.sv
src/sensor_frame_checksum_parser_core.sv
dv/sfcp_frame_checker.sv
dv/tb_sensor_frame_checksum_parser_core.sv
